/* hdl/onl_pkg.sv */
// ----------------------------------------------------------------------------
// onl_pkg
// Shared types and constants of the occupancy night light controller.
// ----------------------------------------------------------------------------
package onl_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned LIGHT_W    = 10;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned ON_W       = 14;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIE_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAND_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_OFF_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_TICKS  = 3'd4;

  localparam logic [9:0]  RST_DARK_THRESHOLD  = 10'd128;
  localparam logic [7:0]  RST_LIE_TICKS       = 8'd80;
  localparam logic [7:0]  RST_STAND_TICKS     = 8'd5;
  localparam logic [9:0]  RST_STILL_OFF_TICKS = 10'd120;
  localparam logic [13:0] RST_SHUTDOWN_TICKS  = 14'd9000;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ON_W-1:0]  ON_MAX    = '1;

  typedef struct packed {
    logic [9:0]  dark_threshold;
    logic [7:0]  lie_ticks;
    logic [7:0]  stand_ticks;
    logic [9:0]  still_off_ticks;
    logic [13:0] shutdown_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       ramp_down;
    logic       ramp_up;
    logic       lamp_on;
  } result_t;

endpackage

/* hdl/onl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// onl_cfg_regs
// Configuration register bank, written by index, no read-back.
// ----------------------------------------------------------------------------
module onl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [onl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [onl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output onl_pkg::cfg_t                 cfg
);
  import onl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold  <= RST_DARK_THRESHOLD;
      cfg_r.lie_ticks       <= RST_LIE_TICKS;
      cfg_r.stand_ticks     <= RST_STAND_TICKS;
      cfg_r.still_off_ticks <= RST_STILL_OFF_TICKS;
      cfg_r.shutdown_ticks  <= RST_SHUTDOWN_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DARK_THRESHOLD:  cfg_r.dark_threshold  <= cfg_wdata[9:0];
        CFG_LIE_TICKS:       cfg_r.lie_ticks       <= cfg_wdata[7:0];
        CFG_STAND_TICKS:     cfg_r.stand_ticks     <= cfg_wdata[7:0];
        CFG_STILL_OFF_TICKS: cfg_r.still_off_ticks <= cfg_wdata[9:0];
        CFG_SHUTDOWN_TICKS:  cfg_r.shutdown_ticks  <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/onl_ctrl.sv */
// ----------------------------------------------------------------------------
// onl_ctrl
// Phase state machine: one step per registered tick, result registered.
// ----------------------------------------------------------------------------
module onl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        occupant_up,
  input  logic [onl_pkg::LIGHT_W-1:0]  light_sample,
  input  onl_pkg::cfg_t               cfg,
  output onl_pkg::result_t            res
);
  import onl_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LIE   = 2'd1,
    PH_STAND = 2'd2,
    PH_ON    = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ON_W-1:0]  on_time_r, on_time_nxt;
  logic             quick_r, quick_nxt;
  result_t          res_r, res_nxt;

  logic             dark;
  logic             rise, fall;
  logic [CNT_W-1:0] count_inc;
  logic [ON_W-1:0]  on_inc;
  logic [CNT_W-1:0] on_count;

  assign dark      = light_sample < cfg.dark_threshold;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + CNT_W'(1);
  assign on_inc    = (on_time_r == ON_MAX) ? on_time_r : on_time_r + ON_W'(1);
  assign on_count  = occupant_up ? '0 : count_inc;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    on_time_nxt = on_time_r;
    quick_nxt   = quick_r & dark;
    rise        = 1'b0;
    fall        = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (dark) begin
          if (quick_r) begin
            phase_nxt = PH_STAND;
            count_nxt = '0;
          end else if (!occupant_up) begin
            phase_nxt = PH_LIE;
            count_nxt = '0;
          end
        end
      end
      PH_LIE: begin
        if (!dark || occupant_up) begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end else if (count_inc >= {2'b00, cfg.lie_ticks}) begin
          phase_nxt = PH_STAND;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
      PH_STAND: begin
        if (!dark) begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end else if (occupant_up) begin
          if (count_inc >= {2'b00, cfg.stand_ticks}) begin
            phase_nxt   = PH_ON;
            count_nxt   = '0;
            on_time_nxt = '0;
            quick_nxt   = 1'b1;
            rise        = 1'b1;
          end else begin
            count_nxt = count_inc;
          end
        end else begin
          count_nxt = '0;
        end
      end
      PH_ON: begin
        on_time_nxt = on_inc;
        count_nxt   = on_count;
        if (!dark || on_inc >= cfg.shutdown_ticks) begin
          quick_nxt = 1'b0;
          fall      = 1'b1;
        end else if (!occupant_up && on_count >= cfg.still_off_ticks) begin
          quick_nxt = 1'b1;
          fall      = 1'b1;
        end
        if (fall) begin
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end
      end
      default: ;
    endcase
    res_nxt.lamp_on   = phase_nxt == PH_ON;
    res_nxt.ramp_up   = rise;
    res_nxt.ramp_down = fall;
    res_nxt.phase     = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      on_time_r <= '0;
      quick_r   <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      on_time_r <= on_time_nxt;
      quick_r   <= quick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* hdl/occupancy_night_light_controller.sv */
// ----------------------------------------------------------------------------
// occupancy_night_light_controller
// Bed-occupancy night light: one result word per poll tick word.
// ----------------------------------------------------------------------------
// Each input word is one poll tick and yields exactly one result word. A word
// is registered on entry, goes through the phase state machine once the result
// side can advance, and lands in the result register, from which it is offered.
// A new tick is taken every cycle while the result side keeps up. The input
// register frees itself whenever the result register is empty or being
// drained, so a held result stalls entry only once the input register is also
// full. Configuration writes take effect on the following cycle.
module occupancy_night_light_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] occupant_up, [10:1] light_sample, [15:11] zero
  input  logic [onl_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] lamp_on, [1] ramp_up, [2] ramp_down, [4:3] phase, [7:5] zero
  output logic [onl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [onl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [onl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import onl_pkg::*;

  cfg_t               cfg;
  result_t            res;
  logic               in_vld_r;
  logic               up_r;
  logic [LIGHT_W-1:0] light_r;
  logic               out_vld_r;
  logic               advance;
  logic               step;

  assign advance   = !out_vld_r || out_tready;
  assign step      = advance && in_vld_r;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      up_r    <= in_tdata[0];
      light_r <= in_tdata[LIGHT_W:1];
    end
  end

  onl_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  onl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .occupant_up  (up_r),
    .light_sample (light_r),
    .cfg          (cfg),
    .res          (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res.phase, res.ramp_down, res.ramp_up, res.lamp_on};

endmodule
